### rtl/core/lbcd_pkg.sv
// shared types and constants for the lru block cache directory
package lbcd_pkg;

    // fixed field widths of the transaction payloads
    localparam int BLOCK_W      = 48;
    localparam int SLOT_FIELD_W = 4;
    localparam int CFG_W        = 5;

    // slots_in_use value after reset
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    // input command codes
    localparam logic CMD_ACCESS = 1'b0;
    localparam logic CMD_FLUSH  = 1'b1;

    // one input transaction
    typedef struct packed {
        logic               cmd;
        logic [BLOCK_W-1:0] block_number;
    } in_item_t;

    // one result transaction
    typedef struct packed {
        logic                    hit;
        logic                    fill;
        logic [SLOT_FIELD_W-1:0] slot_index;
        logic [BLOCK_W-1:0]      fill_block;
        logic                    evicted_valid;
        logic [BLOCK_W-1:0]      evicted_block;
        logic                    last;
    } out_item_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic latch;       // capture the accepted item
        logic flush;       // empty the directory
        logic init;        // load slot 0 with block 0, emit first result
        logic scan_clear;  // reset scan counters and search results
        logic scan;        // step the slot scan
        logic finish;      // update slot and emit final result
    } dp_ctl_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic filled_zero;
        logic scan_done;
        logic out_free;
    } dp_stat_t;

endpackage

### rtl/core/lbcd_ram.sv
// generic single write port ram with registered read
module lbcd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/lbcd_ctrl.sv
// controller state machine of the lru block cache directory
module lbcd_ctrl
    import lbcd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_cmd,
    input  dp_stat_t stat,
    output logic     in_stall,
    output dp_ctl_t  ctl
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_INIT   = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // input is taken only between items
    assign in_stall = (state_reg != ST_IDLE);

    // next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.latch = 1'b1;
                    if (in_cmd == CMD_FLUSH)
                    begin
                        ctl.flush = 1'b1;
                    end
                    else if (stat.filled_zero)
                    begin
                        state_next = ST_INIT;
                    end
                    else
                    begin
                        ctl.scan_clear = 1'b1;
                        state_next     = ST_SCAN;
                    end
                end
            end
            ST_INIT:
            begin
                if (stat.out_free)
                begin
                    ctl.init       = 1'b1;
                    ctl.scan_clear = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                ctl.scan = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    ctl.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/core/lbcd_datapath.sv
// datapath of the lru block cache directory: slot memories, scan, result register
module lbcd_datapath
    import lbcd_pkg::*;
#(
    parameter int SLOTS      = 16,
    parameter int BLOCK_BITS = 48,
    parameter int STAMP_BITS = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  dp_ctl_t          ctl,
    output dp_stat_t         stat,
    input  in_item_t         in_data,
    input  logic             cfg_valid,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             out_stall,
    output logic             out_valid,
    output out_item_t        out_data
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int LIM_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    logic [BLOCK_BITS-1:0] blk_reg;
    logic [CNT_W-1:0]      filled_reg;
    logic [STAMP_BITS-1:0] clock_reg;
    logic [CFG_W-1:0]      cfg_reg;
    logic [CNT_W-1:0]      rd_cnt_reg;
    logic                  pend_valid_reg;
    logic [IDX_W-1:0]      pend_idx_reg;
    logic                  found_reg;
    logic [IDX_W-1:0]      hit_idx_reg;
    logic [STAMP_BITS-1:0] best_age_reg;
    logic [IDX_W-1:0]      victim_idx_reg;
    logic [BLOCK_BITS-1:0] victim_tag_reg;
    logic                  out_valid_reg;
    out_item_t             out_reg;

    logic [BLOCK_BITS-1:0] tag_rdata;
    logic [STAMP_BITS-1:0] stamp_rdata;
    logic [STAMP_BITS-1:0] age;
    logic [STAMP_BITS-1:0] clock_inc;
    logic [LIM_W-1:0]      cfg_ext;
    logic [LIM_W-1:0]      lim;
    logic                  slot_free;
    logic                  rd_more;
    logic                  out_free;
    logic                  tag_we;
    logic                  stamp_we;
    logic [IDX_W-1:0]      wr_idx;
    logic [BLOCK_BITS-1:0] tag_wdata;
    logic [STAMP_BITS-1:0] stamp_wdata;

    // effective slot limit, saturated to 2..SLOTS
    always_comb
    begin
        cfg_ext = LIM_W'(cfg_reg);
        if (cfg_ext < LIM_W'(2))
        begin
            lim = LIM_W'(2);
        end
        else if (cfg_ext > LIM_W'(SLOTS))
        begin
            lim = LIM_W'(SLOTS);
        end
        else
        begin
            lim = cfg_ext;
        end
    end

    assign slot_free = (LIM_W'(filled_reg) < lim);
    assign rd_more   = (rd_cnt_reg < filled_reg);
    assign out_free  = !out_valid_reg || !out_stall;
    assign clock_inc = clock_reg + 1'b1;
    assign age       = clock_reg - stamp_rdata;

    // status toward the controller
    assign stat.filled_zero = (filled_reg == '0);
    assign stat.scan_done   = !rd_more && !pend_valid_reg;
    assign stat.out_free    = out_free;

    // slot memory write side
    always_comb
    begin
        if (ctl.init)
        begin
            wr_idx = '0;
        end
        else if (found_reg)
        begin
            wr_idx = hit_idx_reg;
        end
        else if (slot_free)
        begin
            wr_idx = filled_reg[IDX_W-1:0];
        end
        else
        begin
            wr_idx = victim_idx_reg;
        end
        tag_we      = ctl.init || (ctl.finish && !found_reg);
        stamp_we    = ctl.init || ctl.finish;
        tag_wdata   = ctl.init ? '0 : blk_reg;
        stamp_wdata = (ctl.finish && found_reg) ? clock_reg : clock_inc;
    end

    lbcd_ram #(
        .WIDTH (BLOCK_BITS),
        .DEPTH (SLOTS)
    ) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (wr_idx),
        .wdata (tag_wdata),
        .raddr (rd_cnt_reg[IDX_W-1:0]),
        .rdata (tag_rdata)
    );

    lbcd_ram #(
        .WIDTH (STAMP_BITS),
        .DEPTH (SLOTS)
    ) u_stamp_ram (
        .clk   (clk),
        .we    (stamp_we),
        .waddr (wr_idx),
        .wdata (stamp_wdata),
        .raddr (rd_cnt_reg[IDX_W-1:0]),
        .rdata (stamp_rdata)
    );

    // control state: fill count, fill clock, config, scan pointers, result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg     <= '0;
            clock_reg      <= '0;
            cfg_reg        <= CFG_RESET;
            rd_cnt_reg     <= '0;
            pend_valid_reg <= 1'b0;
            found_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                cfg_reg <= cfg_data;
            end
            if (ctl.flush)
            begin
                filled_reg <= '0;
            end
            else if (ctl.init)
            begin
                filled_reg <= CNT_W'(1);
                clock_reg  <= clock_inc;
            end
            else if (ctl.finish && !found_reg)
            begin
                clock_reg <= clock_inc;
                if (slot_free)
                begin
                    filled_reg <= filled_reg + 1'b1;
                end
            end
            // scan issue and search
            if (ctl.scan_clear)
            begin
                rd_cnt_reg     <= '0;
                pend_valid_reg <= 1'b0;
                found_reg      <= 1'b0;
            end
            else if (ctl.scan)
            begin
                pend_valid_reg <= rd_more;
                if (rd_more)
                begin
                    rd_cnt_reg <= rd_cnt_reg + 1'b1;
                end
                if (pend_valid_reg && !found_reg && (tag_rdata == blk_reg))
                begin
                    found_reg <= 1'b1;
                end
            end
            // result register handshake
            if (ctl.init || ctl.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers: item, search results, result transaction
    always_ff @(posedge clk)
    begin
        if (ctl.latch)
        begin
            blk_reg <= BLOCK_BITS'(in_data.block_number);
        end
        if (ctl.scan)
        begin
            pend_idx_reg <= rd_cnt_reg[IDX_W-1:0];
            if (pend_valid_reg && !found_reg && (tag_rdata == blk_reg))
            begin
                hit_idx_reg <= pend_idx_reg;
            end
            // oldest slot among 1..filled-1, first index on ties
            if (pend_valid_reg && (pend_idx_reg != '0))
            begin
                if ((pend_idx_reg == IDX_W'(1)) || (age > best_age_reg))
                begin
                    best_age_reg   <= age;
                    victim_idx_reg <= pend_idx_reg;
                    victim_tag_reg <= tag_rdata;
                end
            end
        end
        if (ctl.init)
        begin
            out_reg.hit           <= 1'b0;
            out_reg.fill          <= 1'b1;
            out_reg.slot_index    <= '0;
            out_reg.fill_block    <= '0;
            out_reg.evicted_valid <= 1'b0;
            out_reg.evicted_block <= '0;
            out_reg.last          <= 1'b0;
        end
        else if (ctl.finish)
        begin
            out_reg.hit           <= found_reg;
            out_reg.fill          <= !found_reg;
            out_reg.slot_index    <= SLOT_FIELD_W'(wr_idx);
            out_reg.fill_block    <= BLOCK_W'(blk_reg);
            out_reg.evicted_valid <= !found_reg && !slot_free;
            out_reg.evicted_block <= (!found_reg && !slot_free) ?
                                     BLOCK_W'(victim_tag_reg) : '0;
            out_reg.last          <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // fill count never passes the slot count
    a_filled_bound: assert property (@(posedge clk) disable iff (!rst_n)
        filled_reg <= CNT_W'(SLOTS))
        else $error("fill count above slot count");

    // a compare in flight always refers to a filled slot
    a_pend_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (CNT_W'(pend_idx_reg) < filled_reg))
        else $error("scan compare outside filled slots");

    // a hit leaves the fill clock unchanged
    a_hit_clock: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.finish && found_reg) |=> $stable(clock_reg))
        else $error("fill clock moved on a hit");

    // a result is loaded only into a free result register
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.init || ctl.finish) |-> out_free)
        else $error("result register overwritten");

endmodule

### rtl/core/lru_block_cache_directory.sv
// an access scans the filled slots one slot per cycle through the tag/stamp ram read port
// the first access after reset or flush loads slot 0, then does a one-slot scan,
// and gives two result transactions
// a flush gives no result; one item is in work at a time
// a result waits in an output register while the next item is accepted
// reset clears control state and sets slots_in_use to 16; slot memories are not cleared
module lru_block_cache_directory
    import lbcd_pkg::*;
#(
    parameter int SLOTS      = 16,
    parameter int BLOCK_BITS = 48,
    parameter int STAMP_BITS = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_item_t         in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output out_item_t        out_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data
);

    dp_ctl_t  ctl;
    dp_stat_t stat;
    logic     in_stall_int;

    // configuration register always takes a write
    assign cfg_ready = 1'b1;
    assign in_stall  = in_stall_int;

    lbcd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_cmd   (in_data.cmd),
        .stat     (stat),
        .in_stall (in_stall_int),
        .ctl      (ctl)
    );

    lbcd_datapath #(
        .SLOTS      (SLOTS),
        .BLOCK_BITS (BLOCK_BITS),
        .STAMP_BITS (STAMP_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .stat      (stat),
        .in_data   (in_data),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule
